/* design/chbt_pkg.sv */
`timescale 1ns / 1ps
package chbt_pkg;

  localparam int KEY_W        = 16;
  localparam int BUCKETS      = 11;
  localparam int BUCKET_DEPTH = 8;

  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CNT_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int ADDR_W = $clog2(BUCKETS * BUCKET_DEPTH);
  localparam int REM_W  = $clog2(2 * BUCKETS);

  localparam int STATUS_W  = 2;
  localparam int BUCKET_FW = 4;
  localparam int SLOT_FW   = 3;
  localparam int COUNT_FW  = 4;

  // Floor of 2^KEY_W / BUCKETS; the quotient estimate is at most one low.
  localparam logic [KEY_W-1:0] MUL_K = KEY_W'((2 ** KEY_W) / BUCKETS);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [BUCKET_FW-1:0] bucket;
    logic [SLOT_FW-1:0]   slot;
    logic [COUNT_FW-1:0]  count;
  } out_t;

endpackage

/* design/chbt_hash.sv */
`timescale 1ns / 1ps
module chbt_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [chbt_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [chbt_pkg::BKT_W-1:0] bkt
);
  import chbt_pkg::*;

  logic [KEY_W-1:0]   key1_r;
  logic [2*KEY_W-1:0] prod_r;
  logic [REM_W-1:0]   rem_r;
  logic [BKT_W-1:0]   bkt_r;
  logic               v1_r;
  logic               v2_r;
  logic               done_r;

  logic [KEY_W-1:0] quot;
  logic [KEY_W-1:0] qmul;
  logic [KEY_W-1:0] diff;

  assign quot = prod_r[2*KEY_W-1:KEY_W];
  assign qmul = KEY_W'(quot * BUCKETS);
  assign diff = key1_r - qmul;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
    if (start) begin
      key1_r <= key;
      prod_r <= key * MUL_K;
    end
    if (v1_r) begin
      rem_r <= REM_W'(diff);
    end
    if (v2_r) begin
      bkt_r <= (rem_r >= REM_W'(BUCKETS)) ? BKT_W'(rem_r - REM_W'(BUCKETS)) : BKT_W'(rem_r);
    end
  end

  assign done = done_r;
  assign bkt  = bkt_r;

endmodule

/* design/chained_hash_bucket_table_top.sv */
`timescale 1ns / 1ps
// Hash table of 16-bit keys with separate chaining, bucket = key mod BUCKETS, each bucket
// holding up to BUCKET_DEPTH keys in insertion order. One beat in gives one beat out, and
// the block works on one beat at a time. An insert writes its key at the end of the bucket.
// A delete has the search and the compaction together walk the bucket one slot per cycle
// through the single read port of the key memory, and the bucket index comes from a
// reciprocal multiply unit. The key memory needs no clearing; only the bucket counts are
// reset.
module chained_hash_bucket_table_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  chbt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output chbt_pkg::out_t out_data
);
  import chbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_OPER,
    S_SRCH,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t              state_r;
  logic                op_r;
  logic [KEY_W-1:0]    key_r;
  logic [BKT_W-1:0]    bkt_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [ADDR_W-1:0]   base_r;
  logic [CNT_W-1:0]    idx_r;
  logic [CNT_W-1:0]    pidx_r;
  logic                pend_r;
  logic [CNT_W-1:0]    slot_r;
  logic [STATUS_W-1:0] status_r;
  logic [CNT_W-1:0]    counts_r [BUCKETS];
  logic                out_valid_r;
  out_t                out_data_r;

  logic [KEY_W-1:0] mem [BUCKETS * BUCKET_DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  logic              accept;
  logic              hash_done;
  logic [BKT_W-1:0]  hash_bkt;
  logic              hit;
  logic              full;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  chbt_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (in_data.key),
    .done  (hash_done),
    .bkt   (hash_bkt)
  );

  assign hit  = pend_r && (rd_data_r == key_r);
  assign full = (cnt_r == CNT_W'(BUCKET_DEPTH));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = base_r + ADDR_W'(idx_r);
    wr_en   = 1'b0;
    wr_addr = base_r + ADDR_W'(pidx_r) - ADDR_W'(1);
    wr_data = rd_data_r;
    case (state_r)
      S_OPER: begin
        if (op_r == OP_INSERT && !full) begin
          wr_en   = 1'b1;
          wr_addr = base_r + ADDR_W'(cnt_r);
          wr_data = key_r;
        end
      end
      S_SRCH: begin
        rd_en = !hit && (idx_r != cnt_r);
      end
      S_SHIFT: begin
        wr_en = pend_r;
        rd_en = (idx_r != cnt_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < BUCKETS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready && (state_r != S_RESP)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_data.op;
            key_r   <= in_data.key;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bkt_r   <= hash_bkt;
            cnt_r   <= counts_r[hash_bkt];
            base_r  <= ADDR_W'(hash_bkt * BUCKET_DEPTH);
            state_r <= S_OPER;
          end
        end
        S_OPER: begin
          idx_r    <= '0;
          pend_r   <= 1'b0;
          slot_r   <= '0;
          status_r <= ST_DONE;
          if (op_r == OP_INSERT) begin
            if (full) begin
              status_r <= ST_FULL;
            end else begin
              counts_r[bkt_r] <= cnt_r + CNT_W'(1);
              cnt_r           <= cnt_r + CNT_W'(1);
              slot_r          <= cnt_r;
            end
            state_r <= S_RESP;
          end else begin
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (hit) begin
            slot_r  <= pidx_r;
            idx_r   <= pidx_r + CNT_W'(1);
            pend_r  <= 1'b0;
            state_r <= S_SHIFT;
          end else if (idx_r == cnt_r) begin
            pend_r   <= 1'b0;
            status_r <= ST_NOT_FOUND;
            state_r  <= S_RESP;
          end else begin
            pend_r <= 1'b1;
            pidx_r <= idx_r;
            idx_r  <= idx_r + CNT_W'(1);
          end
        end
        S_SHIFT: begin
          if (idx_r == cnt_r) begin
            pend_r          <= 1'b0;
            cnt_r           <= cnt_r - CNT_W'(1);
            counts_r[bkt_r] <= cnt_r - CNT_W'(1);
            state_r         <= S_RESP;
          end else begin
            pend_r <= 1'b1;
            pidx_r <= idx_r;
            idx_r  <= idx_r + CNT_W'(1);
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.status <= status_r;
            out_data_r.bucket <= BUCKET_FW'(bkt_r);
            out_data_r.slot   <= SLOT_FW'(slot_r);
            out_data_r.count  <= COUNT_FW'(cnt_r);
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* dv/chained_hash_bucket_table_top_tb.sv */
`timescale 1ns / 1ps
module chained_hash_bucket_table_top_tb;
  import chbt_pkg::*;

  localparam int RANDOM_OPS = 1900;
  localparam int QUIET_TAIL = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t op_q[$];
  out_t expected_q[$];
  int total_ops = 0;
  int beats_in = 0;
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;

  logic [KEY_W-1:0] chain_keys[BUCKETS][BUCKET_DEPTH];
  int chain_len[BUCKETS];

  logic [KEY_W-1:0] live_keys[$];
  int live_len[BUCKETS];

  chained_hash_bucket_table_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic out_t hash_table_update(in_t item);
    int b;
    int n;
    int hit;
    out_t r;
    b = item.key % BUCKETS;
    n = chain_len[b];
    hit = -1;
    r.status = ST_DONE;
    r.bucket = BUCKET_FW'(b);
    r.slot = '0;
    if (item.op == OP_INSERT) begin
      if (n >= BUCKET_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        chain_keys[b][n] = item.key;
        r.slot = SLOT_FW'(n);
        n++;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (hit < 0 && chain_keys[b][i] == item.key) begin
          hit = i;
        end
      end
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        for (int i = hit; i < n - 1; i++) begin
          chain_keys[b][i] = chain_keys[b][i + 1];
        end
        r.slot = SLOT_FW'(hit);
        n--;
      end
    end
    chain_len[b] = n;
    r.count = COUNT_FW'(n);
    return r;
  endfunction

  // The stimulus side keeps its own multiset of stored keys so that most
  // deletes can name a key that is really present.
  task automatic queue_op(logic op, logic [KEY_W-1:0] key);
    in_t item;
    int b;
    int idx;
    item.op = op;
    item.key = key;
    b = key % BUCKETS;
    idx = -1;
    op_q.push_back(item);
    total_ops++;
    if (op == OP_INSERT) begin
      if (live_len[b] < BUCKET_DEPTH) begin
        live_keys.push_back(key);
        live_len[b]++;
      end
    end else begin
      for (int i = 0; i < live_keys.size(); i++) begin
        if (idx < 0 && live_keys[i] == key) begin
          idx = i;
        end
      end
      if (idx >= 0) begin
        live_keys.delete(idx);
        live_len[b]--;
      end
    end
  endtask

  function automatic logic [KEY_W-1:0] key_in_bucket(int b);
    return KEY_W'(b + BUCKETS * $urandom_range(0, (65535 - b) / BUCKETS));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(hash_table_update(in_data));
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (op_q.size() != 0) begin
          if (op_q.size() > QUIET_TAIL && $urandom_range(0, 99) < 15) begin
            in_gap <= $urandom_range(0, 8);
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            in_data <= op_q.pop_front();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_data.status);
            errors++;
          end
          if (out_data.bucket !== want.bucket) begin
            $display("%0t: bucket expected %0d actual %0d", $time, want.bucket,
                     out_data.bucket);
            errors++;
          end
          if (out_data.slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, out_data.slot);
            errors++;
          end
          if (out_data.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count,
                     out_data.count);
            errors++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (op_q.size() > QUIET_TAIL && $urandom_range(0, 99) < 15) begin
        out_gap <= $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int ins_pct;
    int focus;
    int spread;
    int b;
    logic [KEY_W-1:0] key;
    for (int i = 0; i < BUCKETS; i++) begin
      chain_len[i] = 0;
      live_len[i] = 0;
    end

    queue_op(OP_INSERT, 16'd0);
    queue_op(OP_INSERT, 16'hFFFF);
    queue_op(OP_DELETE, 16'hFFFF);
    queue_op(OP_DELETE, 16'hFFFF);
    queue_op(OP_DELETE, 16'd5);
    queue_op(OP_INSERT, 16'd11);
    queue_op(OP_INSERT, 16'd22);
    queue_op(OP_INSERT, 16'd33);
    queue_op(OP_INSERT, 16'd11);
    queue_op(OP_INSERT, 16'd44);
    queue_op(OP_INSERT, 16'd55);
    queue_op(OP_INSERT, 16'd66);
    queue_op(OP_INSERT, 16'd77);
    queue_op(OP_DELETE, 16'd11);
    queue_op(OP_DELETE, 16'd66);
    queue_op(OP_DELETE, 16'd0);
    queue_op(OP_DELETE, 16'd11);
    queue_op(OP_DELETE, 16'd77);
    queue_op(OP_INSERT, 16'd65534);
    queue_op(OP_DELETE, 16'd65523);
    queue_op(OP_INSERT, 16'h8000);
    queue_op(OP_DELETE, 16'h8000);
    queue_op(OP_DELETE, 16'd65534);

    ins_pct = 50;
    focus = 0;
    spread = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 25;
          1: ins_pct = 50;
          default: ins_pct = 80;
        endcase
        focus = $urandom_range(0, BUCKETS - 1);
        spread = $urandom_range(0, 1);
      end
      b = spread ? $urandom_range(0, BUCKETS - 1) : focus;
      if ($urandom_range(0, 99) < ins_pct) begin
        if ($urandom_range(0, 9) == 0) begin
          key = KEY_W'($urandom_range(0, 65535));
        end else if (live_keys.size() != 0 && $urandom_range(0, 9) == 0) begin
          key = live_keys[$urandom_range(0, live_keys.size() - 1)];
        end else begin
          key = key_in_bucket(b);
        end
        queue_op(OP_INSERT, key);
      end else begin
        if (live_keys.size() != 0 && $urandom_range(0, 99) < 75) begin
          key = live_keys[$urandom_range(0, live_keys.size() - 1)];
        end else if ($urandom_range(0, 1) == 0) begin
          key = key_in_bucket(b);
        end else begin
          key = KEY_W'($urandom_range(0, 65535));
        end
        queue_op(OP_DELETE, key);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_in != total_ops || expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
design/chbt_pkg.sv
design/chbt_hash.sv
design/chained_hash_bucket_table_top.sv
dv/chained_hash_bucket_table_top_tb.sv
